FILE: hw/rtl/lth_pkg.sv
package lth_pkg;

    // Character codes
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_LBRC  = 8'h7b;
    localparam logic [7:0] CHAR_RBRC  = 8'h7d;

    // djb2 seed
    localparam logic [31:0] HASH_SEED = 32'd5381;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 32;
    localparam int HALF_W  = 16;
    localparam int REC_W   = 4 * WORD_W;

    // Line phase
    typedef enum logic [1:0] {
        PH_HEAD  = 2'd0,
        PH_TOKEN = 2'd1,
        PH_REST  = 2'd2,
        PH_SKIP  = 2'd3
    } phase_t;

    // One output record
    typedef struct packed {
        logic [WORD_W-1:0] djb2_value;
        logic [WORD_W-1:0] sum_and_length;
        logic [WORD_W-1:0] token_offset;
        logic [WORD_W-1:0] line_number;
    } record_t;

endpackage

FILE: hw/rtl/line_token_hasher.sv
// Line token hasher: takes a text stream one byte per beat and emits one
// record per line that carries a token (the line's first word).
//
// Input channel s_*: one byte per beat in s_tdata[7:0].
// Output channel m_*: one record per beat, 128 bits of m_tdata:
//   line number, token offset, signed byte sum with length, djb2 hash.
//
// A record appears on m_tvalid in the cycle after the LF or CR ending a
// token line is accepted. One byte per cycle while s_tready is high; the
// per-byte update is a single shift-add of the hash plus the phase decode.
//
// Reset clears the position and line counters, the phase and the output
// valid; the hash restarts at its seed.
//
// When the receiver stalls with a record held, s_tready drops until the
// record is taken; s_tready follows m_tready in the same cycle, so a byte
// and a record move together without a bubble.
module line_token_hasher
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [lth_pkg::BYTE_W-1:0] s_tdata,  // [7:0] byte_in
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // [31:0] line_number, [63:32] token_offset, [95:64] sum_and_length,
    // [127:96] djb2_value
    output logic [lth_pkg::REC_W-1:0] m_tdata
);

    import lth_pkg::*;

    logic                s_accept;
    logic [WORD_W-1:0]   sbyte;
    logic                is_eol;
    logic                is_skip_head;

    logic [WORD_W-1:0]   pos_reg, pos_next;
    logic [WORD_W-1:0]   line_reg, line_next;
    phase_t              phase_reg, phase_next;
    logic                cr_reg, cr_next;
    logic                seen_reg, seen_next;
    logic [WORD_W-1:0]   start_reg, start_next;
    logic [HALF_W-1:0]   len_reg, len_next;
    logic [HALF_W-1:0]   sum_reg, sum_next;
    logic [WORD_W-1:0]   hash_reg, hash_next;

    logic                emit;
    logic                out_valid_reg, out_valid_next;
    record_t             out_reg, out_next;

    // Handshake
    assign s_tready = !out_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    // Byte decode
    assign sbyte        = {{(WORD_W-BYTE_W){s_tdata[BYTE_W-1]}}, s_tdata};
    assign is_eol       = (s_tdata == CHAR_LF) || (s_tdata == CHAR_CR);
    assign is_skip_head = (s_tdata == CHAR_HASH) || (s_tdata == CHAR_LBRC)
                       || (s_tdata == CHAR_RBRC) || (s_tdata == CHAR_TAB);

    // Next state of the line scanner
    always_comb
    begin
        pos_next   = pos_reg;
        line_next  = line_reg;
        phase_next = phase_reg;
        cr_next    = cr_reg;
        seen_next  = seen_reg;
        start_next = start_reg;
        len_next   = len_reg;
        sum_next   = sum_reg;
        hash_next  = hash_reg;
        emit       = 1'b0;
        if (s_accept)
        begin
            pos_next = pos_reg + 1'b1;
            cr_next  = 1'b0;
            if (cr_reg && (s_tdata == CHAR_LF))
            begin
                // LF of a CRLF pair: dropped
            end
            else if (is_eol)
            begin
                line_next  = line_reg + 1'b1;
                cr_next    = (s_tdata == CHAR_CR);
                emit       = seen_reg;
                seen_next  = 1'b0;
                phase_next = PH_HEAD;
            end
            else
            begin
                logic begin_tok;
                logic take_tok;
                begin_tok = 1'b0;
                take_tok  = 1'b0;
                unique case (phase_reg)
                    PH_HEAD:
                    begin
                        if (is_skip_head)
                            phase_next = PH_SKIP;
                        else
                            begin_tok = 1'b1;
                    end
                    PH_TOKEN:
                    begin
                        if (s_tdata == CHAR_NUL)
                            begin_tok = 1'b1;
                        else if ((s_tdata == CHAR_TAB) || (s_tdata == CHAR_SPACE))
                            phase_next = PH_REST;
                        else
                            take_tok = 1'b1;
                    end
                    default:
                    begin
                        if (s_tdata == CHAR_NUL)
                            begin_tok = 1'b1;
                    end
                endcase
                if (begin_tok)
                begin
                    start_next = pos_reg;
                    len_next   = HALF_W'(1);
                    sum_next   = sbyte[HALF_W-1:0];
                    hash_next  = WORD_W'(HASH_SEED * 33) + sbyte;
                    seen_next  = 1'b1;
                    phase_next = PH_TOKEN;
                end
                else if (take_tok)
                begin
                    len_next  = len_reg + 1'b1;
                    sum_next  = sum_reg + sbyte[HALF_W-1:0];
                    hash_next = (hash_reg << 5) + hash_reg + sbyte;
                end
            end
        end
    end

    // Output record and its valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;
        if (emit)
        begin
            out_valid_next          = 1'b1;
            out_next.line_number    = line_next;
            out_next.token_offset   = start_reg;
            out_next.sum_and_length = {len_reg, sum_reg};
            out_next.djb2_value     = hash_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            line_reg      <= '0;
            phase_reg     <= PH_HEAD;
            cr_reg        <= 1'b0;
            seen_reg      <= 1'b0;
            start_reg     <= '0;
            len_reg       <= '0;
            sum_reg       <= '0;
            hash_reg      <= HASH_SEED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            line_reg      <= line_next;
            phase_reg     <= phase_next;
            cr_reg        <= cr_next;
            seen_reg      <= seen_next;
            start_reg     <= start_next;
            len_reg       <= len_next;
            sum_reg       <= sum_next;
            hash_reg      <= hash_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Record payload
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

`ifndef SYNTHESIS
    // A held record always carries the current line count
    a_rec_line: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.line_number == line_reg))
        else $error("record line number out of step with line counter");

    // A line end after a token produces a record next cycle
    a_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && is_eol && seen_reg && !(cr_reg && (s_tdata == CHAR_LF)))
        |=> out_valid_reg)
        else $error("token line end did not produce a record");

    // Every accepted byte advances the stream position by one
    a_pos: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> (pos_reg == $past(pos_reg) + 1'b1))
        else $error("byte position did not advance");

    // A pending token exists only in the token or rest-of-line phase
    a_seen_phase: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg |-> ((phase_reg == PH_TOKEN) || (phase_reg == PH_REST)))
        else $error("token flag set outside token phases");
`endif

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import lth_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASE_BYTES    = 250;
    localparam int HOLD_CYCLES    = 120;

    // Line-token predictor plus the queue of records it expects
    class token_record_board;
        logic [31:0] pos;
        logic [31:0] lines;
        logic [31:0] tok_start;
        logic [31:0] tok_hash;
        logic [15:0] tok_len;
        logic [15:0] tok_sum;
        phase_t      ph;
        bit          cr_pend;
        bit          tok_seen;
        record_t     expected_q[$];
        int          errors;
        int          checked;

        function new();
            pos       = '0;
            lines     = '0;
            tok_start = '0;
            tok_hash  = HASH_SEED;
            tok_len   = '0;
            tok_sum   = '0;
            ph        = PH_HEAD;
            cr_pend   = 1'b0;
            tok_seen  = 1'b0;
            errors    = 0;
            checked   = 0;
        endfunction

        // Fold one signed byte into length, sum and hash
        function void add_byte(logic [7:0] b);
            logic [31:0] sx;
            sx       = {{24{b[7]}}, b};
            tok_len  = tok_len + 16'd1;
            tok_sum  = tok_sum + sx[15:0];
            tok_hash = tok_hash * 32'd33 + sx;
        endfunction

        function void start_token(logic [7:0] b, logic [31:0] at);
            tok_start = at;
            tok_len   = '0;
            tok_sum   = '0;
            tok_hash  = HASH_SEED;
            add_byte(b);
            tok_seen  = 1'b1;
            ph        = PH_TOKEN;
        endfunction

        // Accepted input byte: advance the line state, queue a record on line end
        function void note_byte(logic [7:0] b);
            logic [31:0] at;
            bit          was_cr;
            record_t     r;
            at      = pos;
            was_cr  = cr_pend;
            pos     = pos + 32'd1;
            cr_pend = 1'b0;
            if (was_cr && b == CHAR_LF)
                return;
            if (b == CHAR_LF || b == CHAR_CR)
            begin
                lines = lines + 32'd1;
                if (b == CHAR_CR)
                    cr_pend = 1'b1;
                if (tok_seen)
                begin
                    r.line_number    = lines;
                    r.token_offset   = tok_start;
                    r.sum_and_length = {tok_len, tok_sum};
                    r.djb2_value     = tok_hash;
                    expected_q.push_back(r);
                    tok_seen = 1'b0;
                end
                ph = PH_HEAD;
                return;
            end
            case (ph)
                PH_HEAD:
                begin
                    if (b == CHAR_HASH || b == CHAR_LBRC || b == CHAR_RBRC || b == CHAR_TAB)
                        ph = PH_SKIP;
                    else
                        start_token(b, at);
                end
                PH_TOKEN:
                begin
                    if (b == CHAR_NUL)
                        start_token(b, at);
                    else if (b == CHAR_TAB || b == CHAR_SPACE)
                        ph = PH_REST;
                    else
                        add_byte(b);
                end
                default:
                begin
                    if (b == CHAR_NUL)
                        start_token(b, at);
                end
            endcase
        endfunction

        // Accepted output beat: compare with the oldest expected record
        function void check_record(logic [REC_W-1:0] data);
            record_t got;
            record_t want;
            got = data;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected record: line %h off %h sl %h hash %h",
                             got.line_number, got.token_offset,
                             got.sum_and_length, got.djb2_value);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.line_number != want.line_number || got.token_offset != want.token_offset ||
                got.sum_and_length != want.sum_and_length || got.djb2_value != want.djb2_value)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("mismatch exp: line %h off %h sl %h hash %h",
                             want.line_number, want.token_offset,
                             want.sum_and_length, want.djb2_value);
                    $display("         got: line %h off %h sl %h hash %h",
                             got.line_number, got.token_offset,
                             got.sum_and_length, got.djb2_value);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [BYTE_W-1:0]  s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [REC_W-1:0]   m_tdata;

    token_record_board  sb;
    logic [7:0]         line_q[$];
    int                 send_idle;
    int                 recv_stall;
    int                 hold_cycles;
    int                 bytes_sent;

    line_token_hasher dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Beat monitor: records first, since they come from earlier bytes
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_record(m_tdata);
            if (s_tvalid && s_tready)
                sb.note_byte(s_tdata);
        end
    end

    // Receiver: random stalls, or a counted hold-off when requested
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_stall);
        end
    end

    // Watchdog on cycles with no beat on either side
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no beat for %0d cycles, %0d records outstanding",
                 WATCHDOG_LIMIT, sb.pending());
        $display("FAILED: results differ");
        $finish;
    end

    // Byte that may start or extend a token
    function automatic logic [7:0] token_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CHAR_NUL || b == CHAR_TAB || b == CHAR_SPACE ||
               b == CHAR_LF || b == CHAR_CR);
        return b;
    endfunction

    // Byte for the tail of a line; NUL boosted since it restarts a token
    function automatic logic [7:0] tail_byte();
        logic [7:0] b;
        if ($urandom_range(0, 99) < 15)
            return CHAR_NUL;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CHAR_LF || b == CHAR_CR);
        return b;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_line();
        foreach (line_q[i])
            send_byte(line_q[i]);
    endtask

    // Build one random line into line_q: mostly well formed, some noise
    task automatic make_line();
        int         kind;
        int         n;
        logic [7:0] hd;
        line_q.delete();
        kind = $urandom_range(0, 99);
        if (kind < 15)
        begin
            // noise, may hold its own line ends
            n = $urandom_range(1, 12);
            repeat (n) line_q.push_back(8'($urandom_range(0, 255)));
        end
        else if (kind < 23)
        begin
            // empty line
        end
        else if (kind < 35)
        begin
            // skipped line
            case ($urandom_range(0, 3))
                0: line_q.push_back(CHAR_HASH);
                1: line_q.push_back(CHAR_LBRC);
                2: line_q.push_back(CHAR_RBRC);
                default: line_q.push_back(CHAR_TAB);
            endcase
            n = $urandom_range(0, 6);
            repeat (n) line_q.push_back(tail_byte());
        end
        else
        begin
            // token line, head may be NUL or space
            n = $urandom_range(0, 99);
            if (n < 5)
                hd = CHAR_NUL;
            else if (n < 10)
                hd = CHAR_SPACE;
            else
                do
                    hd = token_byte();
                while (hd == CHAR_HASH || hd == CHAR_LBRC || hd == CHAR_RBRC);
            line_q.push_back(hd);
            n = $urandom_range(0, 10);
            repeat (n) line_q.push_back(token_byte());
            if ($urandom_range(0, 99) < 35)
            begin
                line_q.push_back($urandom_range(0, 1) ? CHAR_TAB : CHAR_SPACE);
                n = $urandom_range(0, 5);
                repeat (n) line_q.push_back(tail_byte());
            end
        end
        case ($urandom_range(0, 2))
            0: line_q.push_back(CHAR_LF);
            1: line_q.push_back(CHAR_CR);
            default:
            begin
                line_q.push_back(CHAR_CR);
                line_q.push_back(CHAR_LF);
            end
        endcase
    endtask

    // Stop offering bytes and wait for every expected record
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int send_tab[4];
        int recv_tab[4];
        int start;
        send_tab    = '{0, 65, 0, 12};
        recv_tab    = '{0, 0, 65, 12};
        sb          = new();
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        send_idle   = 0;
        recv_stall  = 0;
        hold_cycles = 0;
        bytes_sent  = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < 4; p++)
        begin
            send_idle  = send_tab[p];
            recv_stall = recv_tab[p];
            if (p == 2)
                hold_cycles = HOLD_CYCLES;
            if (p == 0)
            begin
                // token with negative bytes, then space and ignored tail
                line_q = '{8'h41, 8'hff, 8'h80, CHAR_SPACE, 8'h78, CHAR_LF,
                           // hash-skipped line with CRLF
                           CHAR_HASH, 8'h71, CHAR_CR, CHAR_LF,
                           // tab head skipped, then NUL starts a token
                           CHAR_TAB, 8'h7a, CHAR_NUL, 8'h6b, CHAR_LF,
                           // space at head is the token's first byte
                           CHAR_SPACE, 8'h7f, CHAR_CR,
                           // LF that completes the CRLF, then brace lines
                           CHAR_LF, CHAR_LBRC, CHAR_LF, CHAR_RBRC, CHAR_CR,
                           // NUL inside a token replaces it
                           8'h6d, CHAR_NUL, 8'h6e, CHAR_CR};
                send_line();
                drain();
            end
            start = bytes_sent;
            while (bytes_sent - start < PHASE_BYTES)
            begin
                make_line();
                send_line();
            end
            drain();
        end

        repeat (8) @(posedge clk);
        $display("Run: %0d bytes over %0d line ends, %0d records checked, %0d errors",
                 bytes_sent, sb.lines, sb.checked, sb.errors);
        $display("Covered four idle mixes, a receiver hold-off, drain pauses, edge-case lines");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
